[src/ptw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    localparam int unsigned TABLE_PAGES_DEFAULT = 8;
    localparam int unsigned ENTRIES_PER_PAGE    = 512;
    localparam int unsigned IDX_W               = 9;
    localparam int unsigned FRAME_W             = 40;
    localparam int unsigned SLOT_W              = 12;
    localparam int unsigned WORD_W              = 64;
    localparam int unsigned VA_W                = 48;
    localparam int unsigned PA_W                = 52;
    localparam int unsigned OFFSET_W            = 12;
    localparam int unsigned LVL_W               = 2;
    localparam int unsigned PRESENT_BIT         = 0;
    localparam int unsigned USER_BIT            = 2;
    localparam int unsigned FRAME_LSB           = 12;

    localparam logic       MODE_WRITE = 1'b0;
    localparam logic       MODE_WALK  = 1'b1;
    localparam logic [1:0] LVL_TOP    = 2'd0;
    localparam logic [1:0] LVL_LEAF   = 2'd3;

    typedef struct packed {
        logic                mode;
        logic [SLOT_W-1:0]   entry_slot;
        logic [WORD_W-1:0]   entry_word;
        logic [VA_W-1:0]     virt_addr;
    } t_in_item;

    typedef struct packed {
        logic                ok;
        logic [PA_W-1:0]     phys_addr;
        logic [LVL_W-1:0]    fault_level;
    } t_out_item;

    typedef enum logic [1:0] {
        RES_WRITE = 2'd0,
        RES_FAULT = 2'd1,
        RES_WALK  = 2'd2
    } t_res_kind;

    typedef struct packed {
        logic              clr_write;
        logic              mem_wr;
        logic              accept;
        logic              rd_root;
        logic              rd_next;
        logic              res_load;
        t_res_kind         res_kind;
        logic [LVL_W-1:0]  level;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic root_in_range;
        logic entry_ok;
        logic next_in_range;
    } t_dp_stat;

endpackage

`default_nettype wire

[src/ptw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptw_ctrl import ptw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire logic     i_mode,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          busy
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_WALK  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [LVL_W-1:0]  r_level, n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_level <= LVL_TOP;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

    always_comb begin
        n_state = r_state;
        n_level = r_level;
        o_cmd   = '0;
        o_cmd.res_kind = RES_WRITE;
        busy    = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_mode == MODE_WRITE) begin
                        o_cmd.mem_wr   = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_kind = RES_WRITE;
                    end else if (i_stat.root_in_range) begin
                        o_cmd.accept  = 1'b1;
                        o_cmd.rd_root = 1'b1;
                        n_level       = LVL_TOP;
                        n_state       = ST_WALK;
                    end else begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_kind = RES_FAULT;
                        o_cmd.level    = LVL_TOP;
                    end
                end
            end
            ST_WALK: begin
                if (!i_stat.entry_ok) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_FAULT;
                    o_cmd.level    = r_level;
                    n_state        = ST_IDLE;
                end else if (r_level == LVL_LEAF) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_WALK;
                    n_state        = ST_IDLE;
                end else if (!i_stat.next_in_range) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_kind = RES_FAULT;
                    o_cmd.level    = r_level + 2'd1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    o_cmd.level   = r_level + 2'd1;
                    n_level       = r_level + 2'd1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/ptw_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module ptw_datapath import ptw_pkg::*; #(
    parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_in_item           i_item,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [FRAME_W-1:0] i_cfg_wr_data,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    output logic                    o_done,
    output t_out_item               o_result
);

    localparam int unsigned DEPTH  = TABLE_PAGES * ENTRIES_PER_PAGE;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [WORD_W-1:0]  r_mem [DEPTH];
    logic [WORD_W-1:0]  r_rd_data;
    logic [FRAME_W-1:0] r_root_frame;
    logic [VA_W-1:0]    r_va;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_done;
    t_out_item          r_result;

    logic [FRAME_W-1:0] ent_frame;
    logic [IDX_W-1:0]   next_idx;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               wr_en;
    logic               slot_in_range;
    logic [FRAME_W+IDX_W-1:0] root_word;
    logic [FRAME_W+IDX_W-1:0] next_word;

    assign ent_frame = r_rd_data[FRAME_LSB +: FRAME_W];

    always_comb begin
        case (i_cmd.level)
            2'd1:    next_idx = r_va[38:30];
            2'd2:    next_idx = r_va[29:21];
            2'd3:    next_idx = r_va[20:12];
            default: next_idx = r_va[47:39];
        endcase
    end

    assign root_word = {r_root_frame, i_item.virt_addr[47:39]};
    assign next_word = {ent_frame, next_idx};
    assign rd_addr   = i_cmd.rd_root ? root_word[ADDR_W-1:0] : next_word[ADDR_W-1:0];

    assign slot_in_range = 32'(i_item.entry_slot) < 32'(DEPTH);
    assign wr_en   = i_cmd.clr_write || (i_cmd.mem_wr && slot_in_range);
    assign wr_addr = i_cmd.clr_write ? r_clr_addr : ADDR_W'(i_item.entry_slot);
    assign wr_data = i_cmd.clr_write ? '0 : i_item.entry_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_root || i_cmd.rd_next) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_frame <= '0;
            r_clr_addr   <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_root_frame <= i_cfg_wr_data;
            end
            if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_done <= i_cmd.res_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_va <= i_item.virt_addr;
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_kind)
                RES_FAULT: begin
                    r_result.ok          <= 1'b0;
                    r_result.phys_addr   <= '0;
                    r_result.fault_level <= i_cmd.level;
                end
                RES_WALK: begin
                    r_result.ok          <= 1'b1;
                    r_result.phys_addr   <= {ent_frame, r_va[OFFSET_W-1:0]};
                    r_result.fault_level <= LVL_TOP;
                end
                default: begin
                    r_result.ok          <= 1'b1;
                    r_result.phys_addr   <= '0;
                    r_result.fault_level <= LVL_TOP;
                end
            endcase
        end
    end

    assign o_stat.clr_last      = r_clr_addr == ADDR_W'(DEPTH - 1);
    assign o_stat.root_in_range = r_root_frame < FRAME_W'(TABLE_PAGES);
    assign o_stat.entry_ok      = r_rd_data[PRESENT_BIT] && r_rd_data[USER_BIT];
    assign o_stat.next_in_range = ent_frame < FRAME_W'(TABLE_PAGES);

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

[src/page_table_walker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Four-level page table walker with an on-chip table store.
// Input channel: drive i_item and raise start; the transaction is taken on
// a clock edge where start is high and busy is low. Mode 0 stores
// entry_word at entry_slot, mode 1 translates virt_addr from the table at
// the root frame set through i_cfg_wr_en / i_cfg_wr_data.
// Result channel: o_done is high for exactly one cycle with o_result valid;
// the receiver cannot stall, so every result must be taken in that cycle.
// Answers: a write answers in the cycle after acceptance. A translation issues
// one table read per level from the single synchronous store, so a full walk
// answers once the leaf entry has been read; a fault answers earlier, after the
// failing level. busy drops as the result is registered, so a new walk is taken
// only after the last one has answered, and writes are taken one per cycle while idle.
// Reset: the root frame returns to zero and the store is swept to zero one
// word a cycle, TABLE_PAGES*512 words (4096 by default), with busy high;
// configuration writes are taken during the sweep.

module page_table_walker import ptw_pkg::*; #(
    parameter int unsigned TABLE_PAGES = TABLE_PAGES_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_in_item           i_item,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [FRAME_W-1:0] i_cfg_wr_data,
    output logic                    o_done,
    output t_out_item               o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ptw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_item.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    ptw_datapath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_done        (o_done),
        .o_result      (o_result)
    );

endmodule

`default_nettype wire
